>>> src/fxm_pkg.sv
// fxm_pkg: shared widths, register codes, reset values and stage enables
// for the field-oriented X-drive mixer. No dependencies.
package fxm_pkg;

    localparam int CMD_W     = 8;   // joystick command width, signed
    localparam int HEAD_W    = 9;   // heading field width
    localparam int DRV_W     = 9;   // wheel command width, signed
    localparam int CFG_W     = 8;   // widest config register
    localparam int CFG_IDX_W = 1;   // two registers
    localparam int ROT_W     = 11;  // rotated forward/strafe, signed
    localparam int MIX_W     = 12;  // f +/- s +/- r, signed

    localparam int IN_TDATA_W  = 40; // 33 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 40; // 36 bits of fields, padded to bytes

    localparam int ROM_DEPTH = 1 << HEAD_W;

    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int HEADING_STEPS_DEF  = 360;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'd1;

    localparam logic [CFG_W-1:0] DEADBAND_RST = 8'd5;
    localparam logic [CFG_W-1:0] LIMIT_RST    = 8'd100;

    // per-stage load enables, from the valid/ready chain in the top level
    typedef struct packed {
        logic rom;   // stage 1: table read, commands registered
        logic mul;   // stage 2: four products
        logic sum;   // stage 3: rotated sums, truncated
        logic mix;   // stage 4: wheel mix
        logic out;   // stage 5: deadband, clamp, output register
    } t_stage_en;

endpackage

>>> src/fxm_trig_rom.sv
// fxm_trig_rom: sine/cosine table in Q1.TRIG_FRAC_BITS, built at elaboration,
// registered read indexed by the raw heading. Depends on fxm_pkg.
module fxm_trig_rom #(
    parameter int TRIG_FRAC_BITS = fxm_pkg::TRIG_FRAC_BITS_DEF,
    parameter int HEADING_STEPS  = fxm_pkg::HEADING_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [fxm_pkg::HEAD_W-1:0]            i_addr,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]      o_cos
);
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam logic [63:0] STEPS64     = 64'(HEADING_STEPS);
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
    localparam int          TERMS       = 16;
    localparam logic [63:0] SIN_DEN [TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
        64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056};
    localparam logic [63:0] COS_DEN [TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
        64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992};

    typedef logic [2*TW-1:0] t_rom [fxm_pkg::ROM_DEPTH];

    // (x*y) >> 62, low 64 bits
    function automatic logic [63:0] mul62(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    function automatic logic signed [TW-1:0] round_q(input logic [63:0] v);
        logic [63:0] t;
        t = (v + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS);
        return t[TW-1:0];
    endfunction

    // Taylor series per quadrant angle, then quadrant swap; wraps at a full turn
    function automatic t_rom build_rom();
        t_rom rom;
        logic [63:0] u, q, r, a, a2, ts, tc, ss, cs;
        logic signed [TW-1:0] sv, cv, so, co;
        for (int k = 0; k < fxm_pkg::ROM_DEPTH; k++) begin
            u  = 64'd4 * (64'(k) % STEPS64);
            q  = u / STEPS64;
            r  = u % STEPS64;
            a  = (HALF_PI_Q62 / STEPS64) * r + ((HALF_PI_Q62 % STEPS64) * r) / STEPS64;
            a2 = mul62(a, a);
            ts = a;
            tc = ONE_Q62;
            ss = '0;
            cs = '0;
            for (int n = 0; n < TERMS; n++) begin
                if (n % 2 == 1) begin
                    ss = ss - ts;
                    cs = cs - tc;
                end else begin
                    ss = ss + ts;
                    cs = cs + tc;
                end
                ts = mul62(ts, a2) / SIN_DEN[n];
                tc = mul62(tc, a2) / COS_DEN[n];
            end
            sv = round_q(ss);
            cv = round_q(cs);
            case (q[1:0])
                2'd0: begin so = sv;  co = cv;  end
                2'd1: begin so = cv;  co = -sv; end
                2'd2: begin so = -sv; co = -cv; end
                default: begin so = -cv; co = sv; end
            endcase
            rom[k] = {so, co};
        end
        return rom;
    endfunction

    localparam t_rom TRIG_ROM = build_rom();

    logic [2*TW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= TRIG_ROM[i_addr];
        end
    end

    assign o_sin = $signed(r_data[2*TW-1:TW]);
    assign o_cos = $signed(r_data[TW-1:0]);

endmodule

>>> src/fxm_rotate.sv
// fxm_rotate: rotates the forward/strafe vector by the heading (stage 2
// products, stage 3 sums truncated toward zero). Depends on fxm_pkg.
module fxm_rotate #(
    parameter int TRIG_FRAC_BITS = fxm_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  fxm_pkg::t_stage_en                     i_en,
    input  logic signed [fxm_pkg::CMD_W-1:0]       i_fwd,
    input  logic signed [fxm_pkg::CMD_W-1:0]       i_str,
    input  logic signed [fxm_pkg::CMD_W-1:0]       i_rot,
    input  logic signed [TRIG_FRAC_BITS+1:0]       i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0]       i_cos,
    output logic signed [fxm_pkg::ROT_W-1:0]       o_f,
    output logic signed [fxm_pkg::ROT_W-1:0]       o_s,
    output logic signed [fxm_pkg::CMD_W-1:0]       o_rot
);
    localparam int PW  = TRIG_FRAC_BITS + fxm_pkg::CMD_W + 2;
    localparam int PSW = TRIG_FRAC_BITS + fxm_pkg::ROT_W;

    logic signed [PW-1:0]            r_fc, r_ss, r_sc, r_fs;
    logic signed [fxm_pkg::CMD_W-1:0] r_rot2, r_rot3;
    logic signed [fxm_pkg::ROT_W-1:0] r_f, r_s;
    logic signed [PSW-1:0]           w_fp, w_sp, w_fb, w_sb;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_fc   <= PW'(i_fwd) * PW'(i_cos);
            r_ss   <= PW'(i_str) * PW'(i_sin);
            r_sc   <= PW'(i_str) * PW'(i_cos);
            r_fs   <= PW'(i_fwd) * PW'(i_sin);
            r_rot2 <= i_rot;
        end
    end

    // bias negative sums by 2^T-1 so the arithmetic shift rounds toward zero
    assign w_fp = PSW'(r_fc) + PSW'(r_ss);
    assign w_sp = PSW'(r_sc) - PSW'(r_fs);
    assign w_fb = w_fp + $signed({{(PSW-TRIG_FRAC_BITS){1'b0}},
                                  {TRIG_FRAC_BITS{w_fp[PSW-1]}}});
    assign w_sb = w_sp + $signed({{(PSW-TRIG_FRAC_BITS){1'b0}},
                                  {TRIG_FRAC_BITS{w_sp[PSW-1]}}});

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_f    <= w_fb[PSW-1:TRIG_FRAC_BITS];
            r_s    <= w_sb[PSW-1:TRIG_FRAC_BITS];
            r_rot3 <= r_rot2;
        end
    end

    assign o_f   = r_f;
    assign o_s   = r_s;
    assign o_rot = r_rot3;

endmodule

>>> src/fxm_wheel.sv
// fxm_wheel: X-drive mix into four wheels (stage 4), then deadband and
// symmetric clamp into the output register (stage 5). Depends on fxm_pkg.
module fxm_wheel (
    input  logic                                 i_clk,
    input  fxm_pkg::t_stage_en                   i_en,
    input  logic signed [fxm_pkg::ROT_W-1:0]     i_f,
    input  logic signed [fxm_pkg::ROT_W-1:0]     i_s,
    input  logic signed [fxm_pkg::CMD_W-1:0]     i_rot,
    input  logic [fxm_pkg::CFG_W-1:0]            i_deadband,
    input  logic [fxm_pkg::CFG_W-1:0]            i_limit,
    output logic signed [fxm_pkg::DRV_W-1:0]     o_lf,
    output logic signed [fxm_pkg::DRV_W-1:0]     o_lb,
    output logic signed [fxm_pkg::DRV_W-1:0]     o_rf,
    output logic signed [fxm_pkg::DRV_W-1:0]     o_rb
);
    localparam int MW = fxm_pkg::MIX_W;

    function automatic logic signed [fxm_pkg::DRV_W-1:0] shape(
        input logic signed [MW-1:0]          v,
        input logic [fxm_pkg::CFG_W-1:0]     db,
        input logic [fxm_pkg::CFG_W-1:0]     lim
    );
        logic [MW-1:0]        mag;
        logic signed [MW-1:0] t, hi_s, lo_s;
        mag  = v[MW-1] ? MW'(-v) : MW'(v);
        t    = (mag <= MW'(db)) ? '0 : v;
        hi_s = $signed(MW'(lim));
        lo_s = -hi_s;
        if (t > hi_s) begin
            t = hi_s;
        end else if (t < lo_s) begin
            t = lo_s;
        end
        return t[fxm_pkg::DRV_W-1:0];
    endfunction

    logic signed [MW-1:0] w_f, w_s, w_r;
    logic signed [MW-1:0] r_mix [4];   // lf, lb, rf, rb
    logic signed [fxm_pkg::DRV_W-1:0] r_lf, r_lb, r_rf, r_rb;

    assign w_f = MW'(i_f);
    assign w_s = MW'(i_s);
    assign w_r = MW'(i_rot);

    always_ff @(posedge i_clk) begin
        if (i_en.mix) begin
            r_mix[0] <= w_f + w_s + w_r;
            r_mix[1] <= w_f - w_s + w_r;
            r_mix[2] <= w_f - w_s - w_r;
            r_mix[3] <= w_f + w_s - w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_lf <= shape(r_mix[0], i_deadband, i_limit);
            r_lb <= shape(r_mix[1], i_deadband, i_limit);
            r_rf <= shape(r_mix[2], i_deadband, i_limit);
            r_rb <= shape(r_mix[3], i_deadband, i_limit);
        end
    end

    assign o_lf = r_lf;
    assign o_lb = r_lb;
    assign o_rf = r_rf;
    assign o_rb = r_rb;

endmodule

>>> src/field_oriented_xdrive_mixer_top.sv
// field_oriented_xdrive_mixer_top: field-oriented X-drive mixer, five-stage
// pipeline. Depends on fxm_pkg, fxm_trig_rom, fxm_rotate, fxm_wheel.
//
//   port group   dir  width  carries
//   i_s_axis_*   in   40     one command word: fwd, strafe, rotate, heading
//   o_m_axis_*   out  40     one wheel word: lf, lb, rf, rb drive
//   i_cfg_*      in   1+8    register writes: deadband, limit
//
// o_m_axis_tvalid rises once the accepted word has passed the five register
// stages; one word per cycle is taken and delivered while the sink keeps
// i_m_axis_tready high.
// Stages: table read, products, rotated sums, wheel mix, deadband/clamp.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and o_s_axis_tready stays high while any stage is free.
// Reset (synchronous, active low) clears the valid bits and loads deadband 5,
// limit 100; the trig table is constant and needs no fill.
module field_oriented_xdrive_mixer_top #(
    parameter int TRIG_FRAC_BITS = fxm_pkg::TRIG_FRAC_BITS_DEF,
    parameter int HEADING_STEPS  = fxm_pkg::HEADING_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] forward_cmd, [15:8] strafe_cmd, [23:16] rotate_cmd,
    // [32:24] heading_deg, [39:33] zero
    input  logic [fxm_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    // wheel stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [8:0] left_front_drive, [17:9] left_back_drive,
    // [26:18] right_front_drive, [35:27] right_back_drive, [39:36] zero
    output logic [fxm_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // config writes
    input  logic                                  i_cfg_we,
    input  logic [fxm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fxm_pkg::CFG_W-1:0]             i_cfg_data
);
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int NS = 5;

    logic [fxm_pkg::CFG_W-1:0]           r_deadband, r_limit;
    logic [NS-1:0]                       r_vld, n_vld;
    logic [NS-1:0]                       w_en;
    fxm_pkg::t_stage_en                  w_stage_en;

    logic signed [fxm_pkg::CMD_W-1:0]    r_fwd1, r_str1, r_rot1;
    logic signed [TW-1:0]                w_sin, w_cos;
    logic signed [fxm_pkg::ROT_W-1:0]    w_f, w_s;
    logic signed [fxm_pkg::CMD_W-1:0]    w_rot3;
    logic signed [fxm_pkg::DRV_W-1:0]    w_lf, w_lb, w_rf, w_rb;
    logic [fxm_pkg::DRV_W-1:0]           w_mag_lf, w_mag_lb, w_mag_rf, w_mag_rb;

    // ---- config registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= fxm_pkg::DEADBAND_RST;
            r_limit    <= fxm_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fxm_pkg::CFG_DEADBAND: r_deadband <= i_cfg_data;
                fxm_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- stage enables: a stage loads when empty or when its successor moves ----
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_stage_en.rom = w_en[0];
    assign w_stage_en.mul = w_en[1];
    assign w_stage_en.sum = w_en[2];
    assign w_stage_en.mix = w_en[3];
    assign w_stage_en.out = w_en[4];

    always_comb begin
        n_vld[0] = w_en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ---- stage 1: commands alongside the table read ----
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_fwd1 <= $signed(i_s_axis_tdata[7:0]);
            r_str1 <= $signed(i_s_axis_tdata[15:8]);
            r_rot1 <= $signed(i_s_axis_tdata[23:16]);
        end
    end

    fxm_trig_rom #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .HEADING_STEPS  (HEADING_STEPS)
    ) u_trig_rom (
        .i_clk  (i_clk),
        .i_en   (w_stage_en.rom),
        .i_addr (i_s_axis_tdata[32:24]),
        .o_sin  (w_sin),
        .o_cos  (w_cos)
    );

    // ---- stages 2-3: rotation ----
    fxm_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .i_clk (i_clk),
        .i_en  (w_stage_en),
        .i_fwd (r_fwd1),
        .i_str (r_str1),
        .i_rot (r_rot1),
        .i_sin (w_sin),
        .i_cos (w_cos),
        .o_f   (w_f),
        .o_s   (w_s),
        .o_rot (w_rot3)
    );

    // ---- stages 4-5: mix, deadband, clamp ----
    fxm_wheel u_wheel (
        .i_clk      (i_clk),
        .i_en       (w_stage_en),
        .i_f        (w_f),
        .i_s        (w_s),
        .i_rot      (w_rot3),
        .i_deadband (r_deadband),
        .i_limit    (r_limit),
        .o_lf       (w_lf),
        .o_lb       (w_lb),
        .o_rf       (w_rf),
        .o_rb       (w_rb)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tdata  = {4'b0, w_rb, w_rf, w_lb, w_lf};

    // magnitudes for the output checks
    assign w_mag_lf = w_lf[fxm_pkg::DRV_W-1] ? fxm_pkg::DRV_W'(-w_lf) : fxm_pkg::DRV_W'(w_lf);
    assign w_mag_lb = w_lb[fxm_pkg::DRV_W-1] ? fxm_pkg::DRV_W'(-w_lb) : fxm_pkg::DRV_W'(w_lb);
    assign w_mag_rf = w_rf[fxm_pkg::DRV_W-1] ? fxm_pkg::DRV_W'(-w_rf) : fxm_pkg::DRV_W'(w_rf);
    assign w_mag_rb = w_rb[fxm_pkg::DRV_W-1] ? fxm_pkg::DRV_W'(-w_rb) : fxm_pkg::DRV_W'(w_rb);

    // ---- assertions ----
    // an empty output register must open the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // a freshly loaded word never exceeds the limit in force when it was shaped
    a_limit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_en[NS-1]) && r_vld[NS-1]) |->
        (w_mag_lf <= fxm_pkg::DRV_W'($past(r_limit)) &&
         w_mag_lb <= fxm_pkg::DRV_W'($past(r_limit)) &&
         w_mag_rf <= fxm_pkg::DRV_W'($past(r_limit)) &&
         w_mag_rb <= fxm_pkg::DRV_W'($past(r_limit))))
        else $error("wheel command beyond drive limit");

    // nonzero drive is above the deadband unless the clamp cut it down
    a_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_en[NS-1]) && r_vld[NS-1]) |->
        ((w_mag_lf == '0 || w_mag_lf > fxm_pkg::DRV_W'($past(r_deadband)) ||
          w_mag_lf == fxm_pkg::DRV_W'($past(r_limit))) &&
         (w_mag_lb == '0 || w_mag_lb > fxm_pkg::DRV_W'($past(r_deadband)) ||
          w_mag_lb == fxm_pkg::DRV_W'($past(r_limit))) &&
         (w_mag_rf == '0 || w_mag_rf > fxm_pkg::DRV_W'($past(r_deadband)) ||
          w_mag_rf == fxm_pkg::DRV_W'($past(r_limit))) &&
         (w_mag_rb == '0 || w_mag_rb > fxm_pkg::DRV_W'($past(r_deadband)) ||
          w_mag_rb == fxm_pkg::DRV_W'($past(r_limit)))))
        else $error("wheel command inside deadband");

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for field_oriented_xdrive_mixer_top, with directed
// table, random command words, stalls, and a bit-exact Q1.14 trig table and mixer model.
// Depends on fxm_pkg and the mixer RTL only.
module testbench;

    localparam int STEPS = fxm_pkg::HEADING_STEPS_DEF;
    localparam int FRAC  = fxm_pkg::TRIG_FRAC_BITS_DEF;

    localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam longint unsigned ONE_Q62     = 64'h4000000000000000;
    localparam longint          TRIG_ONE    = longint'(1) << FRAC;

    // command word fields, declared MSB first so the struct packs like tdata[32:0]
    typedef struct packed {
        logic        [fxm_pkg::HEAD_W-1:0] head;
        logic signed [fxm_pkg::CMD_W-1:0]  rot;
        logic signed [fxm_pkg::CMD_W-1:0]  str;
        logic signed [fxm_pkg::CMD_W-1:0]  fwd;
    } t_cmd;

    // wheel word: [0] left front, [1] left back, [2] right front, [3] right back
    typedef logic [3:0][fxm_pkg::DRV_W-1:0] t_wheels;

    typedef enum logic {ROW_ITEM, ROW_REGS} t_row_kind;

    // one line of the directed plan: a command word (optionally with its answer
    // typed in) or a pair of register values to load while idle
    typedef struct packed {
        t_row_kind                         kind;
        logic signed [fxm_pkg::CMD_W-1:0]  fwd;
        logic signed [fxm_pkg::CMD_W-1:0]  str;
        logic signed [fxm_pkg::CMD_W-1:0]  rot;
        logic        [fxm_pkg::HEAD_W-1:0] head;
        logic                              typed_exp;
        logic signed [fxm_pkg::DRV_W-1:0]  lf;
        logic signed [fxm_pkg::DRV_W-1:0]  lb;
        logic signed [fxm_pkg::DRV_W-1:0]  rf;
        logic signed [fxm_pkg::DRV_W-1:0]  rb;
        logic        [fxm_pkg::CFG_W-1:0]  db;
        logic        [fxm_pkg::CFG_W-1:0]  lim;
    } t_row;

    //  kind      fwd   str   rot  head typ   lf    lb    rf    rb   db   lim
    localparam t_row PLAN [30] = '{
        '{ROW_ITEM,    0,    0,    0,   0, 1,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,  127,    0,    0,   0, 1,  100,  100,  100,  100,   0,   0},
        '{ROW_ITEM, -128,    0,    0,   0, 1, -100, -100, -100, -100,   0,   0},
        '{ROW_ITEM,    0,  127,    0,   0, 1,  100, -100, -100,  100,   0,   0},
        '{ROW_ITEM,    0,    0,  127,   0, 1,  100,  100, -100, -100,   0,   0},
        '{ROW_ITEM,    0,    0, -128,   0, 1, -100, -100,  100,  100,   0,   0},
        // deadband edge: below, equal (both zeroed), just above
        '{ROW_ITEM,    0,    0,    3,   0, 1,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,    0,    0,    5,   0, 1,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,    0,    0,   -6,   0, 1,   -6,   -6,    6,    6,   0,   0},
        // exact quarter turns, then headings past a full turn
        '{ROW_ITEM,  127,    0,    0, 180, 1, -100, -100, -100, -100,   0,   0},
        '{ROW_ITEM,  127,    0,    0,  90, 1, -100,  100,  100, -100,   0,   0},
        '{ROW_ITEM,  127,    0,    0, 360, 1,  100,  100,  100,  100,   0,   0},
        '{ROW_ITEM,  127,    0,    0, 511, 0,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM, -128, -128, -128,  45, 0,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,  127,  127,  127, 359, 0,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,    0, -128,    0, 270, 0,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,   85,  -42,   17,   1, 0,    0,    0,    0,    0,   0,   0},
        // widest limit, no deadband
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0,   0, 255},
        '{ROW_ITEM,  127,  127,  127,   0, 1,  255,  127, -127,  127,   0,   0},
        '{ROW_ITEM, -128, -128, -128,   0, 1, -255, -128,  128, -128,   0,   0},
        // widest deadband: only the 381 sum survives, then clamps
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0, 255, 255},
        '{ROW_ITEM,  127,  127,  127,   0, 1,  255,    0,    0,    0,   0,   0},
        // limit of zero forces zero drive everywhere
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,  127,  127,  127,   0, 1,    0,    0,    0,    0,   0,   0},
        '{ROW_ITEM,    0,    0,    1,   0, 1,    0,    0,    0,    0,   0,   0},
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0,   0,  10},
        '{ROW_ITEM,    0,    0,    1,   0, 1,    1,    1,   -1,   -1,   0,   0},
        // deadband above limit: zero first, then clamp
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0, 200, 100},
        '{ROW_ITEM,  127,  127,    0,   0, 1,  100,    0,    0,  100,   0,   0},
        '{ROW_REGS,    0,    0,    0,   0, 0,    0,    0,    0,    0,   5, 100}
    };

    localparam string WHEEL_NAME [4] = '{"left_front", "left_back", "right_front", "right_back"};

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [fxm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fxm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_we = 1'b0;
    logic [fxm_pkg::CFG_IDX_W-1:0]   cfg_idx = fxm_pkg::CFG_DEADBAND;
    logic [fxm_pkg::CFG_W-1:0]       cfg_data = '0;

    // predictor copy of the registers and the trig ROM
    logic [fxm_pkg::CFG_W-1:0] db_q  = fxm_pkg::DEADBAND_RST;
    logic [fxm_pkg::CFG_W-1:0] lim_q = fxm_pkg::LIMIT_RST;
    int                        sin_q14 [STEPS];
    int                        cos_q14 [STEPS];

    t_wheels pending_wheels [$];   // expected wheel words, oldest first
    int      fails     = 0;
    int      n_wheels  = 0;        // wheel words taken from the block
    bit      calm      = 1'b0;     // both sides run without idling
    bit      held_off  = 1'b0;

    field_oriented_xdrive_mixer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] fwd, [15:8] strafe, [23:16] rotate, [32:24] heading
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [8:0] lf, [17:9] lb, [26:18] rf, [35:27] rb
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // (x*y) >> 62 on unsigned Q62 operands
    function automatic longint unsigned q62_mul(longint unsigned x, longint unsigned y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    // Q1.14 sine/cosine table: first-quadrant angle in Q62, Taylor series with
    // wrapping 64-bit sums, rounded, then folded into the quadrant
    initial begin : trig_build
        longint unsigned u, quad, rem, ang, ang2, ts, tc, ss, cs;
        int              sv, cv;
        for (int k = 0; k < STEPS; k++) begin
            u    = 64'(4 * k);
            quad = u / STEPS;
            rem  = u % STEPS;
            ang  = (HALF_PI_Q62 / STEPS) * rem + ((HALF_PI_Q62 % STEPS) * rem) / STEPS;
            ang2 = q62_mul(ang, ang);
            ts   = ang;
            tc   = ONE_Q62;
            ss   = '0;
            cs   = '0;
            for (int n = 0; n < 16; n++) begin
                if (n % 2) begin
                    ss -= ts;
                    cs -= tc;
                end else begin
                    ss += ts;
                    cs += tc;
                end
                ts = q62_mul(ts, ang2) / 64'((2 * n + 2) * (2 * n + 3));
                tc = q62_mul(tc, ang2) / 64'((2 * n + 1) * (2 * n + 2));
            end
            sv = int'((ss + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
            cv = int'((cs + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
            case (quad[1:0])
                2'd0: begin sin_q14[k] = sv;  cos_q14[k] = cv;  end
                2'd1: begin sin_q14[k] = cv;  cos_q14[k] = -sv; end
                2'd2: begin sin_q14[k] = -sv; cos_q14[k] = -cv; end
                default: begin sin_q14[k] = -cv; cos_q14[k] = sv; end
            endcase
        end
    end

    // deadband first, then the symmetric clamp
    function automatic logic [fxm_pkg::DRV_W-1:0] drive_shape(int v);
        int lim;
        int mag;
        lim = int'(lim_q);
        mag = (v < 0) ? -v : v;
        if (mag <= int'(db_q))
            v = 0;
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        return v[fxm_pkg::DRV_W-1:0];
    endfunction

    // field-oriented rotation (truncated toward zero) and X-drive mix
    function automatic t_wheels xdrive_mix(t_cmd c);
        int      h;
        longint  pf, ps;
        int      f, s, r;
        t_wheels w;
        h  = int'(c.head) % STEPS;
        pf = longint'(c.fwd) * cos_q14[h] + longint'(c.str) * sin_q14[h];
        ps = longint'(c.str) * cos_q14[h] - longint'(c.fwd) * sin_q14[h];
        f  = int'(pf / TRIG_ONE);   // signed division truncates toward zero
        s  = int'(ps / TRIG_ONE);
        r  = int'(c.rot);
        w[0] = drive_shape(f + s + r);
        w[1] = drive_shape(f - s + r);
        w[2] = drive_shape(f - s - r);
        w[3] = drive_shape(f + s - r);
        return w;
    endfunction

    // offer one command word, with an occasional gap ahead of it, and hold it
    // until taken; tvalid stays high into the next call
    task automatic send_cmd(t_cmd c, t_wheels want);
        if (!calm && $urandom_range(0, 99) < 4) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(fxm_pkg::IN_TDATA_W - $bits(t_cmd)){1'b0}}, c};
        do @(posedge i_clk); while (!s_tready);
        pending_wheels.push_back(want);
    endtask

    // stop offering and wait until every expected wheel word is back;
    // every word yields one result, so the pipe is empty then
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_wheels.size() != 0);
    endtask

    task automatic set_regs(logic [fxm_pkg::CFG_W-1:0] db, logic [fxm_pkg::CFG_W-1:0] lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= fxm_pkg::CFG_DEADBAND;
        cfg_data <= db;
        @(posedge i_clk);
        cfg_idx  <= fxm_pkg::CFG_LIMIT;
        cfg_data <= lim;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        db_q      = db;
        lim_q     = lim;
    endtask

    // stimulus: directed plan, then six random phases over register settings
    initial begin : stimulus
        t_cmd       c;
        t_wheels    want;
        int         sel;
        logic [7:0] db, lim;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_REGS) begin
                settle();
                set_regs(PLAN[i].db, PLAN[i].lim);
            end else begin
                c.fwd  = PLAN[i].fwd;
                c.str  = PLAN[i].str;
                c.rot  = PLAN[i].rot;
                c.head = PLAN[i].head;
                want = PLAN[i].typed_exp ? {PLAN[i].rb, PLAN[i].rf, PLAN[i].lb, PLAN[i].lf}
                                         : xdrive_mix(c);
                send_cmd(c, want);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin db = 8'd0;   lim = 8'd255; end
                1: begin db = 8'($urandom_range(0, 40));  lim = 8'($urandom_range(0, 255)); end
                2: begin db = 8'd255; lim = 8'd255; end
                3: begin db = 8'd0;   lim = 8'd0;   end
                4: begin db = 8'($urandom_range(0, 255)); lim = 8'($urandom_range(0, 255)); end
                default: begin db = fxm_pkg::DEADBAND_RST; lim = fxm_pkg::LIMIT_RST; end
            endcase
            set_regs(db, lim);
            calm = (phase == 1);   // one phase with no idling on either side
            repeat (120) begin
                sel    = $urandom_range(0, 9);
                c.fwd  = (sel == 0) ? 8'd0 : 8'($urandom);
                c.str  = (sel == 0) ? 8'd0 : 8'($urandom);
                // small rotate values to work the deadband
                c.rot  = (sel < 3) ? 8'($urandom_range(0, 14) - 7) : 8'($urandom);
                c.head = (sel == 9) ? 9'($urandom_range(360, 511)) : 9'($urandom_range(0, 359));
                send_cmd(c, xdrive_mix(c));
            end
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge i_clk);
        if (fails == 0)
            $display("** field_oriented_xdrive_mixer_top: PASSED **");
        else
            $display("** field_oriented_xdrive_mixer_top: FAILED **");
        $finish;
    end

    // wheel sink: random stalls, plus one long hold-off so the pipe fills
    // and the block drops o_s_axis_tready
    initial begin : wheel_sink
        forever begin
            @(posedge i_clk);
            if (!held_off && n_wheels >= 60) begin
                m_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
                held_off = 1'b1;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // compare each wheel word taken against the oldest expectation
    always @(posedge i_clk) begin : wheel_check
        t_wheels want;
        t_wheels got;
        if (rst_n && m_tvalid && m_tready) begin
            n_wheels++;
            got = m_tdata[$bits(t_wheels)-1:0];
            if (pending_wheels.size() == 0) begin
                $display("%0t: unexpected wheel word %h", $time, got);
                fails++;
            end else begin
                want = pending_wheels.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: %s drive expected %0d, got %0d", $time,
                                 WHEEL_NAME[i], $signed(want[i]), $signed(got[i]));
                        fails++;
                    end
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("** field_oriented_xdrive_mixer_top: FAILED **");
        $finish;
    end

endmodule
